// ----- rtl/core/deadline_counter_thread_scheduler_unit_macros.svh -----
// assertion macros for the deadline counter thread scheduler
// used by the top level; expects clk and rst_n in scope where expanded
`ifndef DEADLINE_COUNTER_THREAD_SCHEDULER_UNIT_MACROS_SVH
`define DEADLINE_COUNTER_THREAD_SCHEDULER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define DCTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define DCTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DCTS_ASSERT_NOW(lbl, ante, cons, msg)
`define DCTS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/core/dcts_pkg.sv -----
// shared types, codes and constants of the deadline counter thread scheduler
// no dependencies; imported by every module of the block
package dcts_pkg;

    // table geometry
    localparam int NUM_THREADS   = 8;
    localparam int CONTEXT_WORDS = 16;
    localparam int SLOT_W        = $clog2(NUM_THREADS);
    localparam int SCAN_W        = $clog2(NUM_THREADS + 1);
    localparam int TID_W         = 4;
    localparam int CNT_W         = 16;
    localparam int SP_W          = 32;

    localparam logic [TID_W-1:0] NO_TID    = TID_W'(NUM_THREADS);
    localparam logic [SP_W-1:0]  CTX_BYTES = SP_W'(4 * CONTEXT_WORDS);
    localparam logic [CNT_W-1:0] FLOOR_RST = CNT_W'(1);

    // action codes
    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_CREATE = 3'd1;
    localparam logic [2:0] ACT_WAIT   = 3'd2;
    localparam logic [2:0] ACT_WAKE   = 3'd3;
    localparam logic [2:0] ACT_END    = 3'd4;
    localparam logic [2:0] ACT_QUERY  = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_FULL        = 2'd1;
    localparam logic [1:0] ST_NOT_STARTED = 2'd2;

    // command beat
    typedef struct packed {
        logic [2:0]       action;
        logic [SP_W-1:0]  cur_stack_ptr;
        logic [SP_W-1:0]  stack_base;
        logic [15:0]      stack_bytes;
        logic [CNT_W-1:0] priority_req;
        logic [2:0]       query_id;
    } dcts_cmd_t;

    // result beat
    typedef struct packed {
        logic [TID_W-1:0] slot_id;
        logic [SP_W-1:0]  next_stack_ptr;
        logic [1:0]       status;
        logic             alive;
        logic             is_waiting;
    } dcts_res_t;

    // one entry of the count memory
    typedef struct packed {
        logic [CNT_W-1:0] reload;
        logic [CNT_W-1:0] run;
    } dcts_cnt_t;

    // write port of the count memory
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        dcts_cnt_t         data;
    } dcts_cnt_wr_t;

    // write port of the stack pointer memory
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [SP_W-1:0]   data;
    } dcts_sp_wr_t;

endpackage

// ----- rtl/core/deadline_counter_thread_scheduler_unit.sv -----
// top level of the deadline counter thread scheduler: control and flag state
// depends on dcts_pkg, dcts_cnt_mem, dcts_sp_mem and the assertion macro header
//
// Usage:
//   Commands enter on cmd, accepted at a clock edge where start is high and
//   busy is low. Each command gives exactly one result beat on result, marked
//   by done for a single cycle; the receiver cannot hold it off, so capture it
//   when done is high. busy drops in the cycle that done is shown, so the next
//   command may be accepted in that same cycle.
//   A tick walks the count memory at one slot per cycle and then reads the
//   stack pointer memory for the pick; every other action gives its result
//   straight from the EXEC state. One command is in flight at a time.
//   count_floor is written through cfg_valid/cfg_ready/cfg_data (always
//   ready) and should only change while the block is idle.
//   Reset clears all flags and counts, sets count_floor to 1 and marks the
//   scheduler as not started; no clearing pass is needed after reset.
`include "deadline_counter_thread_scheduler_unit_macros.svh"

module deadline_counter_thread_scheduler_unit
    import dcts_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  dcts_cmd_t        cmd,
    output logic             done,
    output dcts_res_t        result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data
);

    localparam int STATE_W = 3;
    localparam logic [STATE_W-1:0] S_IDLE = 3'd0;
    localparam logic [STATE_W-1:0] S_EXEC = 3'd1;
    localparam logic [STATE_W-1:0] S_SCAN = 3'd2;
    localparam logic [STATE_W-1:0] S_FIN  = 3'd3;
    localparam logic [STATE_W-1:0] S_OUT  = 3'd4;
    localparam logic [SCAN_W-1:0]  SCAN_END = SCAN_W'(NUM_THREADS);

    logic [STATE_W-1:0]     state_reg, state_next;
    dcts_cmd_t              cmd_reg, cmd_next;
    logic [CNT_W-1:0]       count_floor_reg;
    logic [NUM_THREADS-1:0] created_reg, created_next;
    logic [NUM_THREADS-1:0] waiting_reg, waiting_next;
    logic [SLOT_W-1:0]      cur_reg, cur_next;
    logic                   started_reg, started_next;
    logic [SCAN_W-1:0]      scan_reg, scan_next;
    logic [SLOT_W-1:0]      pick_reg, pick_next;
    logic [CNT_W-1:0]       pick_cnt_reg, pick_cnt_next;
    logic [CNT_W-1:0]       pick_reload_reg, pick_reload_next;
    dcts_res_t              res_reg, res_next;
    logic                   done_reg, done_next;

    dcts_cnt_wr_t      cnt_wr;
    logic [SLOT_W-1:0] cnt_rd_addr;
    dcts_cnt_t         cnt_rd;
    dcts_sp_wr_t       sp_wr;
    logic [SLOT_W-1:0] sp_rd_addr;
    logic [SP_W-1:0]   sp_rd;

    logic              free_found;
    logic [SLOT_W-1:0] free_slot;
    logic [CNT_W-1:0]  prio_clamped;
    logic [SP_W-1:0]   init_sp;
    logic [SLOT_W-1:0] proc_slot;
    logic [CNT_W-1:0]  cnt_dec;
    logic              better;
    logic              res_full;

    // memories
    dcts_cnt_mem u_cnt_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (cnt_wr),
        .rd_addr (cnt_rd_addr),
        .rd_data (cnt_rd)
    );

    dcts_sp_mem u_sp_mem (
        .clk     (clk),
        .wr      (sp_wr),
        .rd_addr (sp_rd_addr),
        .rd_data (sp_rd)
    );

    // first free slot, lowest index wins
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = NUM_THREADS - 1; i >= 0; i--)
        begin
            if (!created_reg[i])
            begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    // create arithmetic
    assign prio_clamped = (cmd_reg.priority_req < count_floor_reg) ? count_floor_reg
                                                                   : cmd_reg.priority_req;
    assign init_sp = cmd_reg.stack_base + SP_W'({cmd_reg.stack_bytes[15:2], 2'b00})
                     - CTX_BYTES;

    // scan datapath: slot read in the previous cycle
    assign proc_slot = SLOT_W'(scan_reg - SCAN_W'(1));
    assign cnt_dec   = (cnt_rd.run == '0) ? '0 : cnt_rd.run - CNT_W'(1);
    assign better    = created_reg[proc_slot] && !waiting_reg[proc_slot]
                       && (cnt_rd.run < pick_cnt_reg);

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        created_next     = created_reg;
        waiting_next     = waiting_reg;
        cur_next         = cur_reg;
        started_next     = started_reg;
        scan_next        = scan_reg;
        pick_next        = pick_reg;
        pick_cnt_next    = pick_cnt_reg;
        pick_reload_next = pick_reload_reg;
        res_next         = res_reg;
        done_next        = 1'b0;
        cnt_wr           = '0;
        sp_wr            = '0;
        cnt_rd_addr      = scan_reg[SLOT_W-1:0];
        sp_rd_addr       = pick_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_next         = '0;
                res_next.slot_id = NO_TID;
                state_next       = S_IDLE;
                done_next        = 1'b1;
                unique case (cmd_reg.action)
                    ACT_TICK:
                    begin
                        done_next  = 1'b0;
                        state_next = S_SCAN;
                        scan_next  = '0;
                        if (started_reg)
                        begin
                            sp_wr.en   = 1'b1;
                            sp_wr.addr = cur_reg;
                            sp_wr.data = cmd_reg.cur_stack_ptr;
                        end
                        else
                        begin
                            started_next = 1'b1;
                            cur_next     = '0;
                        end
                    end
                    ACT_CREATE:
                    begin
                        if (free_found)
                        begin
                            cnt_wr.en               = 1'b1;
                            cnt_wr.addr             = free_slot;
                            cnt_wr.data.reload      = prio_clamped;
                            cnt_wr.data.run         = prio_clamped;
                            sp_wr.en                = 1'b1;
                            sp_wr.addr              = free_slot;
                            sp_wr.data              = init_sp;
                            created_next[free_slot] = 1'b1;
                            waiting_next[free_slot] = 1'b0;
                            res_next.slot_id        = TID_W'(free_slot);
                        end
                        else
                        begin
                            res_next.status = ST_FULL;
                        end
                    end
                    ACT_WAIT, ACT_END:
                    begin
                        if (!started_reg)
                        begin
                            res_next.status = ST_NOT_STARTED;
                        end
                        else
                        begin
                            waiting_next[cur_reg] = (cmd_reg.action == ACT_WAIT);
                            if (cmd_reg.action == ACT_END)
                            begin
                                created_next[cur_reg] = 1'b0;
                            end
                            res_next.slot_id = TID_W'(cur_reg);
                        end
                    end
                    ACT_WAKE:
                    begin
                        waiting_next = '0;
                    end
                    ACT_QUERY:
                    begin
                        res_next.slot_id = TID_W'(cmd_reg.query_id);
                        if (TID_W'(cmd_reg.query_id) < NO_TID)
                        begin
                            res_next.alive      = created_reg[cmd_reg.query_id];
                            res_next.is_waiting = waiting_reg[cmd_reg.query_id];
                        end
                    end
                    default:
                    begin
                        res_next.slot_id = NO_TID;
                    end
                endcase
            end
            S_SCAN:
            begin
                // process the slot read last cycle, write back its decremented count
                if (scan_reg != '0)
                begin
                    cnt_wr.en          = 1'b1;
                    cnt_wr.addr        = proc_slot;
                    cnt_wr.data.reload = cnt_rd.reload;
                    cnt_wr.data.run    = cnt_dec;
                    if (proc_slot == '0 || better)
                    begin
                        pick_next        = proc_slot;
                        pick_cnt_next    = cnt_dec;
                        pick_reload_next = cnt_rd.reload;
                    end
                end
                if (scan_reg == SCAN_END)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    scan_next = scan_reg + SCAN_W'(1);
                end
            end
            S_FIN:
            begin
                // reload the pick and fetch its saved pointer
                cnt_wr.en          = 1'b1;
                cnt_wr.addr        = pick_reg;
                cnt_wr.data.reload = pick_reload_reg;
                cnt_wr.data.run    = pick_reload_reg;
                cur_next           = pick_reg;
                state_next         = S_OUT;
            end
            S_OUT:
            begin
                res_next                = '0;
                res_next.slot_id        = TID_W'(pick_reg);
                res_next.next_stack_ptr = sp_rd;
                res_next.status         = ST_OK;
                done_next               = 1'b1;
                state_next              = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_floor_reg <= FLOOR_RST;
            created_reg     <= '0;
            waiting_reg     <= '0;
            cur_reg         <= '0;
            started_reg     <= 1'b0;
            scan_reg        <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            created_reg <= created_next;
            waiting_reg <= waiting_next;
            cur_reg     <= cur_next;
            started_reg <= started_next;
            scan_reg    <= scan_next;
            done_reg    <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                count_floor_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        pick_reg        <= pick_next;
        pick_cnt_reg    <= pick_cnt_next;
        pick_reload_reg <= pick_reload_next;
        res_reg         <= res_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = res_reg;
    assign cfg_ready = 1'b1;

    // full-table result beat
    assign res_full = done && (result.status == ST_FULL);

    // checks
    `DCTS_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy, "accepted beat did not raise busy")
    `DCTS_ASSERT_NOW(a_done_when_idle, done, !busy, "result strobe while still busy")
    `DCTS_ASSERT_NOW(a_fin_after_scan, state_reg == S_FIN, scan_reg == SCAN_END, "scan cut short")
    `DCTS_ASSERT_NOW(a_full_has_no_slot, res_full, result.slot_id == NO_TID, "full names a slot")

endmodule

// ----- rtl/core/dcts_cnt_mem.sv -----
// count memory: reload and run counts per slot, one write and one read port
// depends on dcts_pkg; entries never written read as zero via valid bits
module dcts_cnt_mem
    import dcts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dcts_cnt_wr_t      wr,
    input  logic [SLOT_W-1:0] rd_addr,
    output dcts_cnt_t         rd_data
);

    dcts_cnt_t              mem [NUM_THREADS];
    logic [NUM_THREADS-1:0] valid_reg;
    dcts_cnt_t              rd_data_reg;
    logic                   rd_valid_reg;

    // entry storage and registered read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // per-entry valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // unwritten entries hold the reset value
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ----- rtl/core/dcts_sp_mem.sv -----
// saved stack pointer memory, one write and one registered read port
// depends on dcts_pkg; contents undefined until written
module dcts_sp_mem
    import dcts_pkg::*;
(
    input  logic              clk,
    input  dcts_sp_wr_t       wr,
    input  logic [SLOT_W-1:0] rd_addr,
    output logic [SP_W-1:0]   rd_data
);

    logic [SP_W-1:0] mem [NUM_THREADS];
    logic [SP_W-1:0] rd_data_reg;

    // storage and registered read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sim/tb_deadline_counter_thread_scheduler_unit.sv -----
// testbench for deadline_counter_thread_scheduler_unit: directed table, then random phases
// depends on dcts_pkg and the block's rtl; checks every result beat against a local model or a typed table row
`timescale 1ns / 1ps

module tb_deadline_counter_thread_scheduler_unit;
    import dcts_pkg::*;

    localparam int          PHASES        = 7;
    localparam int          PHASE_ITEMS   = 150;
    localparam int          CYCLE_LIMIT   = 300000;
    localparam int          TAIL_CYCLES   = 2 * (NUM_THREADS + 5);
    // action codes the block leaves unused
    localparam logic [2:0]  ACT_SPARE_LO  = 3'd6;
    localparam logic [2:0]  ACT_SPARE_HI  = 3'd7;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    dcts_cmd_t        cmd;
    logic             done;
    dcts_res_t        result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data;

    // local copy of the thread table
    bit               sched_created [NUM_THREADS];
    bit               sched_waiting [NUM_THREADS];
    logic [CNT_W-1:0] sched_reload  [NUM_THREADS];
    logic [CNT_W-1:0] sched_run     [NUM_THREADS];
    logic [SP_W-1:0]  sched_sp      [NUM_THREADS];
    int unsigned      sched_cur;
    bit               sched_started;
    logic [CNT_W-1:0] sched_floor;

    // results owed by the block, oldest first
    dcts_res_t        sched_results_due [$];

    // directed table
    dcts_cmd_t        dir_cmd   [$];
    bit               dir_typed [$];
    dcts_res_t        dir_res   [$];

    int               fail_count = 0;
    int               cycle_count = 0;
    int               n_cmds;
    int               n_ticks;
    int               n_idle_picks;
    int               n_creates;
    int               n_full;
    int               n_ends;
    int               n_floor_writes;
    int               n_checked = 0;

    deadline_counter_thread_scheduler_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_deadline_counter_thread_scheduler_unit failed");
            $finish;
        end
    end

    // apply one command to the local table and return its result beat
    function automatic dcts_res_t sched_apply(input dcts_cmd_t c);
        dcts_res_t        r;
        int unsigned      pick;
        bit               placed;
        bit               any_ready;
        logic [CNT_W-1:0] prio;
        r         = '0;
        r.slot_id = NO_TID;
        case (c.action)
            ACT_TICK:
            begin
                n_ticks++;
                if (sched_started)
                    sched_sp[sched_cur] = c.cur_stack_ptr;
                else
                begin
                    sched_cur     = 0;
                    sched_started = 1'b1;
                end
                // scan from slot 0; the pick's count may already be decremented
                pick      = 0;
                any_ready = 1'b0;
                for (int i = 0; i < NUM_THREADS; i++)
                begin
                    if (sched_created[i] && !sched_waiting[i])
                        any_ready = 1'b1;
                    if (sched_created[i] && !sched_waiting[i] && sched_run[i] < sched_run[pick])
                        pick = i;
                    if (sched_run[i] != '0)
                        sched_run[i] = sched_run[i] - 1'b1;
                end
                if (!any_ready)
                    n_idle_picks++;
                sched_run[pick]  = sched_reload[pick];
                sched_cur        = pick;
                r.slot_id        = TID_W'(pick);
                r.next_stack_ptr = sched_sp[pick];
            end
            ACT_CREATE:
            begin
                n_creates++;
                placed = 1'b0;
                for (int i = 0; i < NUM_THREADS && !placed; i++)
                begin
                    if (!sched_created[i])
                    begin
                        // word-aligned top of stack minus one saved context, wraps mod 2^32
                        sched_sp[i] = c.stack_base + SP_W'({c.stack_bytes[15:2], 2'b00})
                                      - CTX_BYTES;
                        prio = (c.priority_req < sched_floor) ? sched_floor : c.priority_req;
                        sched_reload[i]  = prio;
                        sched_run[i]     = prio;
                        sched_created[i] = 1'b1;
                        sched_waiting[i] = 1'b0;
                        r.slot_id        = TID_W'(i);
                        placed           = 1'b1;
                    end
                end
                if (!placed)
                begin
                    r.status = ST_FULL;
                    n_full++;
                end
            end
            ACT_WAIT, ACT_END:
            begin
                if (!sched_started)
                    r.status = ST_NOT_STARTED;
                else
                begin
                    if (c.action == ACT_WAIT)
                        sched_waiting[sched_cur] = 1'b1;
                    else
                    begin
                        sched_created[sched_cur] = 1'b0;
                        sched_waiting[sched_cur] = 1'b0;
                        n_ends++;
                    end
                    r.slot_id = TID_W'(sched_cur);
                end
            end
            ACT_WAKE:
            begin
                for (int i = 0; i < NUM_THREADS; i++)
                    sched_waiting[i] = 1'b0;
            end
            ACT_QUERY:
            begin
                r.slot_id    = TID_W'(c.query_id);
                r.alive      = sched_created[c.query_id];
                r.is_waiting = sched_waiting[c.query_id];
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // table row; a typed row carries its result beat with zero pointer and flags
    task automatic add_row(input logic [2:0] act, input logic [SP_W-1:0] sp_now,
                           input logic [SP_W-1:0] base, input logic [15:0] bytes,
                           input logic [CNT_W-1:0] prio, input logic [2:0] qid,
                           input bit typed, input logic [TID_W-1:0] tid,
                           input logic [1:0] st);
        dcts_cmd_t c;
        dcts_res_t r;
        c.action        = act;
        c.cur_stack_ptr = sp_now;
        c.stack_base    = base;
        c.stack_bytes   = bytes;
        c.priority_req  = prio;
        c.query_id      = qid;
        r               = '0;
        r.slot_id       = tid;
        r.status        = st;
        dir_cmd.push_back(c);
        dir_typed.push_back(typed);
        dir_res.push_back(r);
    endtask

    function automatic dcts_cmd_t random_cmd();
        dcts_cmd_t c;
        int        roll;
        roll            = $urandom_range(0, 99);
        c.cur_stack_ptr = $urandom;
        c.stack_base    = $urandom;
        c.stack_bytes   = 16'($urandom_range(0, 65535));
        c.priority_req  = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 65535))
                                                      : CNT_W'($urandom_range(0, 12));
        c.query_id      = 3'($urandom_range(0, 7));
        if (roll < 35)
            c.action = ACT_TICK;
        else if (roll < 52)
            c.action = ACT_CREATE;
        else if (roll < 60)
            c.action = ACT_WAIT;
        else if (roll < 68)
            c.action = ACT_WAKE;
        else if (roll < 78)
            c.action = ACT_END;
        else if (roll < 95)
            c.action = ACT_QUERY;
        else
            c.action = ($urandom_range(0, 1) == 0) ? ACT_SPARE_LO : ACT_SPARE_HI;
        return c;
    endfunction

    // send one command beat; entered and left at a falling edge, start left high
    task automatic issue_cmd(input dcts_cmd_t c, input int gap, input bit typed,
                             input dcts_res_t typed_res);
        dcts_res_t r;
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start = 1'b1;
        cmd   = c;
        do
            @(posedge clk);
        while (busy);
        r = sched_apply(c);
        sched_results_due.push_back(typed ? typed_res : r);
        n_cmds++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        start = 1'b0;
        while (sched_results_due.size() != 0)
            @(negedge clk);
    endtask

    // count_floor beat, only while idle
    task automatic write_floor(input logic [CNT_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sched_floor = value;
        n_floor_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // result checker
    always @(posedge clk)
    begin
        dcts_res_t want;
        bit        bad;
        if (rst_n && done)
        begin
            if (sched_results_due.size() == 0)
            begin
                $error("result beat with nothing outstanding: slot_id %0d", result.slot_id);
                fail_count++;
            end
            else
            begin
                want = sched_results_due.pop_front();
                bad  = 1'b0;
                n_checked++;
                if (result.slot_id !== want.slot_id)
                begin
                    $error("slot_id: expected %0d, got %0d", want.slot_id, result.slot_id);
                    bad = 1'b1;
                end
                if (result.next_stack_ptr !== want.next_stack_ptr)
                begin
                    $error("next_stack_ptr: expected %h, got %h",
                           want.next_stack_ptr, result.next_stack_ptr);
                    bad = 1'b1;
                end
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    bad = 1'b1;
                end
                if (result.alive !== want.alive)
                begin
                    $error("alive: expected %0b, got %0b", want.alive, result.alive);
                    bad = 1'b1;
                end
                if (result.is_waiting !== want.is_waiting)
                begin
                    $error("is_waiting: expected %0b, got %0b", want.is_waiting,
                           result.is_waiting);
                    bad = 1'b1;
                end
                if (bad)
                    fail_count++;
            end
        end
    end

    // stimulus
    initial
    begin
        logic [CNT_W-1:0] floor_plan [PHASES];
        dcts_res_t        unused_res;
        bit               quiet;
        int               gap;

        start          = 1'b0;
        cmd            = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        rst_n          = 1'b0;
        n_cmds         = 0;
        n_ticks        = 0;
        n_idle_picks   = 0;
        n_creates      = 0;
        n_full         = 0;
        n_ends         = 0;
        n_floor_writes = 0;
        unused_res     = '0;
        for (int i = 0; i < NUM_THREADS; i++)
        begin
            sched_created[i] = 1'b0;
            sched_waiting[i] = 1'b0;
            sched_reload[i]  = '0;
            sched_run[i]     = '0;
            sched_sp[i]      = '0;
        end
        sched_cur     = 0;
        sched_started = 1'b0;
        sched_floor   = FLOOR_RST;

        // before any tick: commands that need a started scheduler, a query, a wake, spare codes
        add_row(ACT_WAIT,     32'h0,        32'h0,        16'h0,    16'h0,    3'd0, 1, NO_TID,
                ST_NOT_STARTED);
        add_row(ACT_END,      32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 3'd7, 1, NO_TID,
                ST_NOT_STARTED);
        add_row(ACT_QUERY,    32'h0,        32'h0,        16'h0,    16'h0,    3'd0, 1, 4'd0,
                ST_OK);
        add_row(ACT_WAKE,     32'h0,        32'h0,        16'h0,    16'h0,    3'd0, 1, NO_TID,
                ST_OK);
        add_row(ACT_SPARE_LO, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 3'd7, 1, NO_TID,
                ST_OK);
        add_row(ACT_SPARE_HI, 32'h0,        32'h0,        16'h0,    16'h0,    3'd0, 1, NO_TID,
                ST_OK);
        // slot 0 filled before the first tick; tiny stack wraps, zero priority hits the floor
        add_row(ACT_CREATE,   32'h0,        32'h0,        16'h0,    16'h0,    3'd0, 1, 4'd0,
                ST_OK);
        add_row(ACT_CREATE,   32'h0,        32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 3'd0, 0, 4'd0,
                ST_OK);
        add_row(ACT_CREATE,   32'h0,        32'h00001000, 16'h0103, 16'd3,    3'd0, 0, 4'd0,
                ST_OK);
        add_row(ACT_CREATE,   32'h0,        32'h20000000, 16'h0200, 16'd2,    3'd0, 0, 4'd0,
                ST_OK);
        add_row(ACT_CREATE,   32'h0,        32'h20000400, 16'h0041, 16'd5,    3'd0, 0, 4'd0,
                ST_OK);
        add_row(ACT_CREATE,   32'h0,        32'h20000800, 16'h0040, 16'd1,    3'd0, 0, 4'd0,
                ST_OK);
        add_row(ACT_CREATE,   32'h0,        32'h20000C00, 16'h0100, 16'd4,    3'd0, 0, 4'd0,
                ST_OK);
        add_row(ACT_CREATE,   32'h0,        32'h20001000, 16'h0100, 16'd2,    3'd0, 0, 4'd0,
                ST_OK);
        // table full
        add_row(ACT_CREATE,   32'h0,        32'h30000000, 16'h0100, 16'd1,    3'd0, 1, NO_TID,
                ST_FULL);
        // first tick saves nothing
        add_row(ACT_TICK,     32'hFFFFFFFF, 32'h0,        16'h0,    16'h0,    3'd0, 0, 4'd0,
                ST_OK);
        add_row(ACT_TICK,     32'h00001230, 32'h0,        16'h0,    16'h0,    3'd0, 0, 4'd0,
                ST_OK);
        add_row(ACT_WAIT,     32'h0,        32'h0,        16'h0,    16'h0,    3'd0, 0, 4'd0,
                ST_OK);
        add_row(ACT_TICK,     32'h00004560, 32'h0,        16'h0,    16'h0,    3'd0, 0, 4'd0,
                ST_OK);
        add_row(ACT_QUERY,    32'h0,        32'h0,        16'h0,    16'h0,    3'd7, 0, 4'd0,
                ST_OK);
        add_row(ACT_WAKE,     32'h0,        32'h0,        16'h0,    16'h0,    3'd0, 1, NO_TID,
                ST_OK);
        add_row(ACT_END,      32'h0,        32'h0,        16'h0,    16'h0,    3'd0, 0, 4'd0,
                ST_OK);
        add_row(ACT_QUERY,    32'h0,        32'h0,        16'h0,    16'h0,    3'd3, 0, 4'd0,
                ST_OK);
        add_row(ACT_CREATE,   32'h0,        32'h40000000, 16'h0080, 16'd0,    3'd0, 0, 4'd0,
                ST_OK);
        add_row(ACT_TICK,     32'h0,        32'h0,        16'h0,    16'h0,    3'd0, 0, 4'd0,
                ST_OK);

        floor_plan[0] = 16'hFFFF;
        floor_plan[1] = 16'h0000;
        floor_plan[2] = CNT_W'($urandom_range(0, 65535));
        floor_plan[3] = 16'd1;
        floor_plan[4] = CNT_W'($urandom_range(0, 8));
        floor_plan[5] = 16'h0000;
        floor_plan[6] = CNT_W'($urandom_range(0, 20));

        // reset
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part with the reset floor
        foreach (dir_cmd[k])
            issue_cmd(dir_cmd[k], $urandom_range(0, 15), dir_typed[k], dir_res[k]);

        // random phases, each under its own floor
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            write_floor(floor_plan[ph]);
            quiet = (ph % 3 == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                gap = quiet ? 0 : $urandom_range(0, 15);
                issue_cmd(random_cmd(), gap, 1'b0, unused_res);
            end
        end

        // drain and watch for stray beats
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("ran %0d commands: %0d ticks (%0d with no ready thread), %0d creates",
                 n_cmds, n_ticks, n_idle_picks, n_creates);
        $display("%0d creates refused, %0d ends, count_floor written %0d times, %0d beats compared",
                 n_full, n_ends, n_floor_writes, n_checked);
        if (fail_count == 0)
            $display("tb_deadline_counter_thread_scheduler_unit passed");
        else
            $display("tb_deadline_counter_thread_scheduler_unit failed");
        $finish;
    end

endmodule
